// ===== design/ablc_pkg.sv =====
// Shared types and constants for the ADC level band classifier.
// Used by every module of the block and by the port checker. No dependencies.
package ablc_pkg;

  localparam int unsigned NUM_CHANNELS = 2;
  localparam int unsigned SAMPLE_BITS  = 12;
  localparam int unsigned CHAN_BITS    = 1;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned AVG_W        = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned ALPHA_W      = FRAC_BITS + 1;
  localparam int unsigned NUM_BOUNDS   = 6;
  localparam int unsigned BAND_W       = 3;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = ALPHA_W;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(1 << FRAC_BITS);
  localparam logic [BAND_W-1:0]  BAND_RESET  = BAND_W'(5);
  localparam logic [BAND_W-1:0]  BAND_NONE   = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA  = 3'd0,
    CFG_BOUND0 = 3'd1,
    CFG_BOUND1 = 3'd2,
    CFG_BOUND2 = 3'd3,
    CFG_BOUND3 = 3'd4,
    CFG_BOUND4 = 3'd5,
    CFG_BOUND5 = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CHAN_BITS-1:0]   channel;
    logic [SAMPLE_BITS-1:0] raw_sample;
  } ablc_in_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] channel_out;
    logic [BAND_W-1:0]    band;
  } ablc_out_t;

  // One state entry per channel: stored band and running average.
  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [AVG_W-1:0]  avg;
  } ablc_entry_t;

  // Alpha is kept clamped to one, beta is one minus alpha.
  typedef struct packed {
    logic [ALPHA_W-1:0]                         alpha;
    logic [ALPHA_W-1:0]                         beta;
    logic [NUM_BOUNDS-1:0][SAMPLE_BITS-1:0]     bound;
  } ablc_cfg_t;

  localparam ablc_entry_t ENTRY_RESET = '{band: BAND_RESET, avg: '0};

  localparam ablc_cfg_t CFG_RESET = '{
    alpha: ALPHA_W'(52429),
    beta:  ALPHA_W'(13107),
    bound: {12'd4095, 12'd3413, 12'd2730, 12'd2048, 12'd1365, 12'd682}
  };

endpackage

// ===== design/adc_level_band_classifier.sv =====
// Top level of the ADC level band classifier: config registers, compute stage, output register.
// Depends on ablc_pkg, ablc_state_mem and ablc_update.
//
//  port group   direction  handshake               payload
//  in_*         sink       in_valid_i/in_ready_o    ablc_in_t  (channel, raw_sample)
//  out_*        source     out_valid_o/out_ready_i  ablc_out_t (channel_out, band)
//  cfg_*        sink       cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One request per cycle. The state read issued at acceptance returns the next cycle,
// where the update, band lookup and write-back run; a band change then passes through
// the output register to out_*. Back-to-back requests on one channel use the forwarded
// entry. Reset needs no clearing pass: per-channel valid bits give the reset state.
// The input stalls only while a band change waits behind an unaccepted output.
module adc_level_band_classifier (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  ablc_pkg::ablc_in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output ablc_pkg::ablc_out_t                   out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ablc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ablc_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  ablc_pkg::ablc_cfg_t                  cfg_q, cfg_d;
  logic [ablc_pkg::ALPHA_W-1:0]         alpha_clamp;

  logic                                 s1_valid_q;
  logic                                 s1_ok_q;
  logic [ablc_pkg::CHAN_BITS-1:0]       s1_chan_q;
  logic [ablc_pkg::SAMPLE_BITS-1:0]     s1_sample_q;

  logic                                 out_valid_q;
  ablc_pkg::ablc_out_t                  out_q;

  logic                                 in_fire;
  logic                                 in_ok;
  ablc_pkg::ablc_entry_t                old_entry;
  ablc_pkg::ablc_entry_t                new_entry;
  logic                                 changed;
  logic                                 need_out;
  logic                                 s1_adv;
  logic                                 wr_en;

  // configuration
  assign cfg_ready_o = 1'b1;
  assign alpha_clamp = (cfg_data_i > ablc_pkg::ALPHA_ONE) ? ablc_pkg::ALPHA_ONE : cfg_data_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (ablc_pkg::cfg_idx_e'(cfg_index_i)) inside
        ablc_pkg::CFG_ALPHA: begin
          cfg_d.alpha = alpha_clamp;
          cfg_d.beta  = ablc_pkg::ALPHA_ONE - alpha_clamp;
        end
        ablc_pkg::CFG_BOUND0, ablc_pkg::CFG_BOUND1, ablc_pkg::CFG_BOUND2,
        ablc_pkg::CFG_BOUND3, ablc_pkg::CFG_BOUND4, ablc_pkg::CFG_BOUND5: begin
          cfg_d.bound[ablc_pkg::CFG_IDX_W'(cfg_index_i - 3'd1)] =
            cfg_data_i[ablc_pkg::SAMPLE_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ablc_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // compute stage
  assign in_fire  = in_valid_i && in_ready_o;
  assign in_ok    = (32'(in_data_i.channel) < ablc_pkg::NUM_CHANNELS);
  assign need_out = s1_valid_q && s1_ok_q && changed;
  assign s1_adv   = !need_out || !out_valid_q || out_ready_i;
  assign wr_en    = s1_valid_q && s1_ok_q && s1_adv;
  assign in_ready_o = !s1_valid_q || s1_adv;

  ablc_state_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_data_i.channel),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_chan_q),
    .wr_data_i (new_entry),
    .rd_data_o (old_entry)
  );

  ablc_update u_upd (
    .cfg_i     (cfg_q),
    .sample_i  (s1_sample_q),
    .old_i     (old_entry),
    .new_o     (new_entry),
    .changed_o (changed)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_chan_q   <= in_data_i.channel;
      s1_sample_q <= in_data_i.raw_sample;
      s1_ok_q     <= in_ok;
    end
    if (need_out && s1_adv) begin
      out_q.channel_out <= s1_chan_q;
      out_q.band        <= new_entry.band;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      // hold the result until taken, load the next change behind it
      if (need_out && s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/ablc_state_mem.sv =====
// Per-channel state store: synchronous memory of average and band, registered read.
// Valid bits stand in for the reset contents; a same-cycle write is forwarded.
// Depends on ablc_pkg.
module ablc_state_mem (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  rd_en_i,
  input  logic [ablc_pkg::CHAN_BITS-1:0]        rd_addr_i,
  input  logic                                  wr_en_i,
  input  logic [ablc_pkg::CHAN_BITS-1:0]        wr_addr_i,
  input  ablc_pkg::ablc_entry_t                 wr_data_i,
  output ablc_pkg::ablc_entry_t                 rd_data_o
);

  ablc_pkg::ablc_entry_t                  mem [ablc_pkg::NUM_CHANNELS];
  logic [ablc_pkg::NUM_CHANNELS-1:0]      valid_q;
  ablc_pkg::ablc_entry_t                  rd_q;
  logic                                   rd_valid_q;
  logic                                   fwd_q;
  ablc_pkg::ablc_entry_t                  fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
        // the array still holds the old entry when read and write meet
        fwd_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  assign rd_data_o = fwd_q      ? fwd_data_q :
                     rd_valid_q ? rd_q       : ablc_pkg::ENTRY_RESET;

endmodule

// ===== design/ablc_update.sv =====
// Average update and band lookup for one sample: two multiplies, a sum, five range checks.
// Depends on ablc_pkg.
module ablc_update (
  input  ablc_pkg::ablc_cfg_t                   cfg_i,
  input  logic [ablc_pkg::SAMPLE_BITS-1:0]      sample_i,
  input  ablc_pkg::ablc_entry_t                 old_i,
  output ablc_pkg::ablc_entry_t                 new_o,
  output logic                                  changed_o
);

  localparam int unsigned PS_W  = ablc_pkg::ALPHA_W + ablc_pkg::SAMPLE_BITS;
  localparam int unsigned PA_W  = ablc_pkg::ALPHA_W + ablc_pkg::AVG_W;
  localparam int unsigned ACC_W = PA_W + 1;

  logic [PS_W-1:0]               prod_s;
  logic [PA_W-1:0]               prod_a;
  logic [ACC_W-1:0]              acc;
  logic [ablc_pkg::AVG_W-1:0]    avg;
  logic [ablc_pkg::BAND_W-1:0]   band;
  logic [ablc_pkg::AVG_W-1:0]    lo;
  logic [ablc_pkg::AVG_W-1:0]    hi;

  assign prod_s = PS_W'(cfg_i.alpha) * PS_W'(sample_i);
  assign prod_a = PA_W'(cfg_i.beta) * PA_W'(old_i.avg);
  // round half up before dropping the fraction of the product
  assign acc    = ACC_W'({prod_s, ablc_pkg::FRAC_BITS'(0)}) + ACC_W'(prod_a)
                + ACC_W'(1 << (ablc_pkg::FRAC_BITS - 1));
  assign avg    = acc[ablc_pkg::FRAC_BITS +: ablc_pkg::AVG_W];

  // higher bands override lower ones; nothing matching leaves band 0
  always_comb begin
    band = ablc_pkg::BAND_NONE;
    lo   = '0;
    hi   = '0;
    for (int b = 1; b < ablc_pkg::NUM_BOUNDS; b++) begin
      lo = {cfg_i.bound[b-1], ablc_pkg::FRAC_BITS'(0)};
      hi = {cfg_i.bound[b],   ablc_pkg::FRAC_BITS'(0)};
      if ((lo < avg) && (avg <= hi)) begin
        band = ablc_pkg::BAND_W'(b);
      end
    end
  end

  assign new_o.avg  = avg;
  assign new_o.band = band;
  assign changed_o  = (band != old_i.band);

endmodule

// ===== design/ablc_checker.sv =====
// Port-level checker for the ADC level band classifier, bound to the top level.
// Depends on ablc_pkg and adc_level_band_classifier.
module ablc_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_o,
  input  logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  input  ablc_pkg::ablc_out_t                   out_data_o
);

  // a waiting result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_band_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.band <= ablc_pkg::BAND_RESET)
    else $error("band out of range");

  // a fresh result always comes from an accepted request, through the compute stage and output register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching request");

  // the input stalls only behind a blocked output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

bind adc_level_band_classifier ablc_checker u_ablc_checker (.*);
